[hw/rtl/scfr_pkg.sv]
// Package: types, codes and constants of the serial command frame receiver.
package scfr_pkg;

  localparam logic [7:0] HdrByte  = 8'h2A;
  localparam logic [7:0] TailByte = 8'h23;

  // Command code reset values
  localparam logic [7:0] RstCodeMode      = 8'd1;
  localparam logic [7:0] RstCodeDir       = 8'd2;
  localparam logic [7:0] RstCodeSpeedMode = 8'd3;
  localparam logic [7:0] RstCodeDuty      = 8'd4;
  localparam logic [7:0] RstCodeSpeed     = 8'd5;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CODE_MODE       = 3'd0,
    REG_CODE_DIR        = 3'd1,
    REG_CODE_SPEED_MODE = 3'd2,
    REG_CODE_DUTY       = 3'd3,
    REG_CODE_SPEED      = 3'd4
  } reg_idx_e;

  // Frame parser states
  typedef enum logic [1:0] {
    ST_HUNT,
    ST_BODY,
    ST_TAIL,
    ST_CSUM
  } parse_state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       motor_running;
  } in_t;

  typedef struct packed {
    logic        frame_accepted;
    logic        frame_error;
    logic [7:0]  run_mode;
    logic [7:0]  rotation_dir;
    logic [7:0]  speed_mode;
    logic [15:0] duty_value;
    logic [15:0] target_speed;
  } out_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] data;
  } cfg_t;

  // Parser to decoder: a good frame completes on this beat, with its payload
  typedef struct packed {
    logic       ok;
    logic [7:0] cmd;
    logic [7:0] arg_lo;
    logic [7:0] arg_hi;
  } frame_t;

endpackage

[hw/rtl/scfr_chan_if.sv]
// Interface: valid/ready channel with a typed payload.
interface scfr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/scfr_parser.sv]
// Frame parser: header hunt, payload capture, tail check and additive checksum.
module scfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  output scfr_pkg::frame_t  frame_o,
  output logic              error_o
);
  import scfr_pkg::*;

  parse_state_e state_q, state_d;
  logic [1:0]   idx_q, idx_d;
  logic [7:0]   sum_q, sum_d;
  logic         error_q, error_d;
  logic [7:0]   payload_q [3];
  logic [7:0]   total;
  logic         load_body;

  assign total = sum_q + rx_byte_i;

  // Next state, running sum and error flag
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    error_d   = error_q;
    load_body = 1'b0;
    frame_o   = '0;
    frame_o.cmd    = payload_q[0];
    frame_o.arg_lo = payload_q[1];
    frame_o.arg_hi = payload_q[2];
    if (step_i) begin
      unique case (state_q)
        ST_HUNT: begin
          if (rx_byte_i == HdrByte) begin
            state_d = ST_BODY;
            idx_d   = 2'd0;
            sum_d   = rx_byte_i;
          end
        end
        ST_BODY: begin
          load_body = 1'b1;
          sum_d     = total;
          idx_d     = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            state_d = ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (rx_byte_i == TailByte) begin
            state_d = ST_CSUM;
            sum_d   = total;
          end else begin
            state_d = ST_HUNT;
            error_d = 1'b1;
          end
        end
        ST_CSUM: begin
          state_d    = ST_HUNT;
          sum_d      = total;
          frame_o.ok = (total == 8'h00);
          error_d    = (total != 8'h00);
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      idx_q   <= 2'd0;
      sum_q   <= 8'h00;
      error_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      error_q <= error_d;
    end
  end

  // Capture payload bytes
  always_ff @(posedge clk_i) begin
    if (load_body) begin
      payload_q[idx_q] <= rx_byte_i;
    end
  end

  assign error_o = error_q;

endmodule

[hw/rtl/scfr_decoder.sv]
// Command decoder: command code registers and motor setting registers.
module scfr_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  scfr_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  logic              motor_running_i,
  input  scfr_pkg::frame_t  frame_i,
  output logic [7:0]        run_mode_o,
  output logic [7:0]        rotation_dir_o,
  output logic [7:0]        speed_mode_o,
  output logic [15:0]       duty_value_o,
  output logic [15:0]       target_speed_o
);
  import scfr_pkg::*;

  logic [7:0]  code_mode_q, code_dir_q, code_smode_q, code_duty_q, code_speed_q;
  logic [7:0]  mode_q, dir_q, smode_q;
  logic [15:0] duty_q, speed_q;
  logic [15:0] word;
  logic        apply;

  assign word  = {frame_i.arg_hi, frame_i.arg_lo};
  assign apply = step_i && frame_i.ok;

  // Write command code registers; ignore indexes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_mode_q  <= RstCodeMode;
      code_dir_q   <= RstCodeDir;
      code_smode_q <= RstCodeSpeedMode;
      code_duty_q  <= RstCodeDuty;
      code_speed_q <= RstCodeSpeed;
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        REG_CODE_MODE:       code_mode_q  <= cfg_i.data;
        REG_CODE_DIR:        code_dir_q   <= cfg_i.data;
        REG_CODE_SPEED_MODE: code_smode_q <= cfg_i.data;
        REG_CODE_DUTY:       code_duty_q  <= cfg_i.data;
        REG_CODE_SPEED:      code_speed_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Apply each matching command of a good frame; mode and direction only while the motor is stopped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 8'h00;
      dir_q   <= 8'h00;
      smode_q <= 8'h00;
      duty_q  <= 16'h0000;
      speed_q <= 16'h0000;
    end else if (apply) begin
      if (frame_i.cmd == code_mode_q && !motor_running_i) begin
        mode_q <= frame_i.arg_lo;
      end
      if (frame_i.cmd == code_dir_q && !motor_running_i) begin
        dir_q <= frame_i.arg_lo;
      end
      if (frame_i.cmd == code_smode_q) begin
        smode_q <= frame_i.arg_lo;
      end
      if (frame_i.cmd == code_duty_q) begin
        duty_q <= word;
      end
      if (frame_i.cmd == code_speed_q) begin
        speed_q <= word;
      end
    end
  end

  assign run_mode_o     = mode_q;
  assign rotation_dir_o = dir_q;
  assign speed_mode_o   = smode_q;
  assign duty_value_o   = duty_q;
  assign target_speed_o = speed_q;

endmodule

[hw/rtl/serial_command_frame_receiver_top.sv]
// Top level: serial command frame receiver with byte input, result output and config port.
//
// Takes one received byte per beat and returns one result beat per byte in the cycle
// after it is taken. Frames are header 0x2A, command, operand low, operand high, tail 0x23
// and a checksum byte that brings the 8-bit sum of all six bytes to zero. The result
// carries a pulse for a good frame, the error flag and the current motor settings after
// that byte. A new byte can be taken every cycle; the single result register is the only
// buffer, so a byte is taken whenever that register is empty or drains in the same
// cycle. Command codes are written through the config port, which is always ready.
module serial_command_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  scfr_chan_if.sink   in_i,
  scfr_chan_if.source out_o,
  scfr_chan_if.sink   cfg_i
);
  import scfr_pkg::*;

  in_t    in_beat;
  cfg_t   cfg_beat;
  frame_t frame;
  logic   step;
  logic   cfg_we;
  logic   error;
  logic   out_valid_q;
  logic   accepted_q;
  out_t   out_beat;

  assign in_beat  = in_i.payload;
  assign cfg_beat = cfg_i.payload;

  // Take a byte when the result register is free or drains now
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign step        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  scfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_beat.rx_byte),
    .frame_o   (frame),
    .error_o   (error)
  );

  scfr_decoder u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_i           (cfg_beat),
    .step_i          (step),
    .motor_running_i (in_beat.motor_running),
    .frame_i         (frame),
    .run_mode_o      (out_beat.run_mode),
    .rotation_dir_o  (out_beat.rotation_dir),
    .speed_mode_o    (out_beat.speed_mode),
    .duty_value_o    (out_beat.duty_value),
    .target_speed_o  (out_beat.target_speed)
  );

  // Result register: load on each byte beat, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
      accepted_q  <= frame.ok;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_beat.frame_accepted = accepted_q;
  assign out_beat.frame_error    = error;
  assign out_o.valid             = out_valid_q;
  assign out_o.payload           = out_beat;

  // A good frame never shows the error flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && accepted_q) |-> !error)
    else $error("frame accepted with error flag set");

  // Each byte beat yields a result beat in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("byte beat without result");

  // A stalled result keeps its settings and flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_beat))
    else $error("stalled result changed");

endmodule
